### src/lsps_pkg.sv
// ----------------------------------------------------------------------------
// lsps_pkg
// shared constants, register codes and types of the line-of-sight smoother
// ----------------------------------------------------------------------------
package lsps_pkg;

  localparam int GATE_REGS        = 4;
  localparam int POLE_W           = 16;
  localparam int GATE_W           = 64;
  localparam int CFG_W            = 15;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int FIFO_DEPTH       = 4;

  localparam int NUM_GATES_DEF    = 4;
  localparam int MAX_SAMPLES_DEF  = 128;
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int ID_WIDTH_DEF     = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATE_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ELLIPSE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd6;

  localparam logic [CFG_W-1:0] RADIUS_RST   = 15'd1024;
  localparam logic [CFG_W-1:0] ELLIPSE_RST  = 15'd2990;
  localparam logic [CFG_W-1:0] STEP_RST     = 15'd205;
  // 0.01 in q3.12
  localparam logic [CFG_W-1:0] CLEAR_MARGIN = 15'd41;

  typedef struct packed {
    logic done;
    logic hit;
  } lsps_status_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### src/lsps_sqrt.sv
// ----------------------------------------------------------------------------
// lsps_sqrt
// iterative integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module lsps_sqrt #(
  parameter int W = 36
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     operand,
  output logic             done,
  output logic [W/2-1:0]   root
);

  localparam int CW = $clog2(W/2 + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  res;
  logic [W-1:0]  bitm;
  logic [CW-1:0] cnt;
  logic          running;
  logic [W-1:0]  trial;

  assign trial = res + bitm;
  assign root  = res[W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(W/2);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= operand;
      res  <= '0;
      bitm <= {2'b01, {(W-2){1'b0}}};
    end else if (running) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

### src/lsps_div.sv
// ----------------------------------------------------------------------------
// lsps_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsps_div #(
  parameter int W = 36
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          running;
  logic [W:0]    remsh;
  logic          fits;

  assign remsh = {rem, quo[W-1]};
  assign fits  = remsh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (running) begin
      if (fits) begin
        rem <= W'(remsh - {1'b0, dvs});
      end else begin
        rem <= remsh[W-1:0];
      end
      quo <= {quo[W-2:0], fits};
    end
  end

endmodule

### src/lsps_engine.sv
// ----------------------------------------------------------------------------
// lsps_engine
// segment collision test: sequencer around one multiplier, sqrt and divider
// ----------------------------------------------------------------------------
module lsps_engine #(
  parameter int CW = 16,
  parameter int NG = 4,
  parameter int MS = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [CW-1:0]          ax,
  input  logic signed [CW-1:0]          ay,
  input  logic signed [CW-1:0]          bx,
  input  logic signed [CW-1:0]          by,
  input  logic [lsps_pkg::GATE_W-1:0]   gates [NG],
  input  logic [lsps_pkg::CFG_W-1:0]    radius,
  input  logic [lsps_pkg::CFG_W-1:0]    ellipse,
  input  logic [lsps_pkg::CFG_W-1:0]    step,
  output lsps_pkg::lsps_status_t        status
);

  import lsps_pkg::*;

  localparam int PW  = imax(CW, POLE_W);
  localparam int MW  = PW + 1;
  localparam int SQW = 2 * MW + 2;
  localparam int RW  = SQW / 2;
  localparam int TW  = MW + 2;
  localparam int IW  = $clog2(MS + 1);
  localparam int KW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int EW  = imax(RW, CFG_W) + 1;

  localparam logic [3:0] E_IDLE = 4'd0;
  localparam logic [3:0] E_LX   = 4'd1;
  localparam logic [3:0] E_LY   = 4'd2;
  localparam logic [3:0] E_LS   = 4'd3;
  localparam logic [3:0] E_LW   = 4'd4;
  localparam logic [3:0] E_SM   = 4'd5;
  localparam logic [3:0] E_SD   = 4'd6;
  localparam logic [3:0] E_SW   = 4'd7;
  localparam logic [3:0] E_GX   = 4'd8;
  localparam logic [3:0] E_GY   = 4'd9;
  localparam logic [3:0] E_GS   = 4'd10;
  localparam logic [3:0] E_GW   = 4'd11;

  logic [3:0]           state;
  logic signed [CW-1:0] anc_x, anc_y, sx, sy;
  logic [MW-1:0]        mx, my;
  logic                 sgx, sgy;
  logic [RW-1:0]        len, dl;
  logic [TW-1:0]        t;
  logic [IW-1:0]        i;
  logic [KW-1:0]        k;
  logic                 axis, side;
  logic [2*MW-1:0]      acc, prod;

  logic signed [CW:0]   dx, dy;
  logic [MW-1:0]        mul_a, mul_b;
  logic [POLE_W-1:0]    px, py;
  logic signed [MW-1:0] ddx, ddy;
  logic [MW-1:0]        ex, ey;
  logic                 sq_start, sq_done;
  logic [SQW-1:0]       sq_in;
  logic [RW-1:0]        sq_root;
  logic                 dv_start, dv_done;
  logic [SQW-1:0]       dv_num, dv_den, dv_quo;
  logic [CW:0]          q;
  logic signed [CW:0]   coord;
  logic [CFG_W-1:0]     step_eff;
  logic [TW-1:0]        t_next;
  logic [IW-1:0]        i_next;
  logic                 more;
  logic [EW-1:0]        rval, dl_e, dr_e, sum_e;
  logic                 circle, hit;

  assign dx = {bx[CW-1], bx} - {ax[CW-1], ax};
  assign dy = {by[CW-1], by} - {ay[CW-1], ay};

  // pole of the current gate and side
  always_comb begin
    px = side ? gates[k][47:32] : gates[k][15:0];
    py = side ? gates[k][63:48] : gates[k][31:16];
  end

  assign ddx = {{(MW-CW){sx[CW-1]}}, sx} - {{(MW-POLE_W){px[POLE_W-1]}}, px};
  assign ddy = {{(MW-CW){sy[CW-1]}}, sy} - {{(MW-POLE_W){py[POLE_W-1]}}, py};
  assign ex  = ddx[MW-1] ? MW'(-ddx) : MW'(ddx);
  assign ey  = ddy[MW-1] ? MW'(-ddy) : MW'(ddy);

  // shared multiplier operands
  always_comb begin
    case (state)
      E_LX: begin
        mul_a = mx;
        mul_b = mx;
      end
      E_LY: begin
        mul_a = my;
        mul_b = my;
      end
      E_SM: begin
        mul_a = axis ? my : mx;
        mul_b = t[MW-1:0];
      end
      E_GX: begin
        mul_a = ex;
        mul_b = ex;
      end
      E_GY: begin
        mul_a = ey;
        mul_b = ey;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_start = (state == E_LS) || (state == E_GS);
  assign sq_in    = {2'b00, acc} + {2'b00, prod};
  assign dv_start = (state == E_SD);
  assign dv_num   = {1'b0, prod, 1'b0} + {{(SQW-RW){1'b0}}, len};
  assign dv_den   = {{(SQW-RW-1){1'b0}}, len, 1'b0};

  lsps_sqrt #(.W(SQW)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_in),
    .done    (sq_done),
    .root    (sq_root)
  );

  lsps_div #(.W(SQW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // rounded offset along the current axis
  assign q = {1'b0, dv_quo[CW-1:0]};
  always_comb begin
    if (axis) begin
      coord = sgy ? {anc_y[CW-1], anc_y} - signed'(q) : {anc_y[CW-1], anc_y} + signed'(q);
    end else begin
      coord = sgx ? {anc_x[CW-1], anc_x} - signed'(q) : {anc_x[CW-1], anc_x} + signed'(q);
    end
  end

  assign step_eff = (step == '0) ? CFG_W'(1) : step;
  assign t_next   = t + TW'(step_eff);
  assign i_next   = i + 1'b1;
  assign more     = (i_next < IW'(MS)) && (t_next <= TW'(len));

  // gate test with the left distance held and the right one just out
  assign rval   = EW'(radius - CLEAR_MARGIN);
  assign dl_e   = EW'(dl);
  assign dr_e   = EW'(sq_root);
  assign sum_e  = dl_e + dr_e;
  assign circle = (radius > CLEAR_MARGIN) && ((dl_e < rval) || (dr_e < rval));
  assign hit    = circle || (sum_e < EW'(ellipse));

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      status <= '0;
    end else begin
      status <= '0;
      case (state)
        E_IDLE: begin
          if (start) begin
            anc_x <= ax;
            anc_y <= ay;
            sgx   <= dx[CW];
            sgy   <= dy[CW];
            mx    <= MW'(dx[CW] ? -dx : dx);
            my    <= MW'(dy[CW] ? -dy : dy);
            state <= E_LX;
          end
        end
        E_LX: state <= E_LY;
        E_LY: begin
          acc   <= prod;
          state <= E_LS;
        end
        E_LS: state <= E_LW;
        E_LW: begin
          if (sq_done) begin
            len   <= sq_root;
            i     <= '0;
            t     <= '0;
            axis  <= 1'b0;
            state <= E_SM;
          end
        end
        E_SM: begin
          if ((t == '0) || (len == '0)) begin
            if (axis) begin
              sy    <= anc_y;
              axis  <= 1'b0;
              k     <= '0;
              side  <= 1'b0;
              state <= E_GX;
            end else begin
              sx   <= anc_x;
              axis <= 1'b1;
            end
          end else begin
            state <= E_SD;
          end
        end
        E_SD: state <= E_SW;
        E_SW: begin
          if (dv_done) begin
            if (axis) begin
              sy    <= coord[CW-1:0];
              axis  <= 1'b0;
              k     <= '0;
              side  <= 1'b0;
              state <= E_GX;
            end else begin
              sx    <= coord[CW-1:0];
              axis  <= 1'b1;
              state <= E_SM;
            end
          end
        end
        E_GX: state <= E_GY;
        E_GY: begin
          acc   <= prod;
          state <= E_GS;
        end
        E_GS: state <= E_GW;
        E_GW: begin
          if (sq_done) begin
            if (!side) begin
              dl    <= sq_root;
              side  <= 1'b1;
              state <= E_GX;
            end else if (hit) begin
              status <= '{done: 1'b1, hit: 1'b1};
              state  <= E_IDLE;
            end else if (k != KW'(NG - 1)) begin
              k     <= k + 1'b1;
              side  <= 1'b0;
              state <= E_GX;
            end else if (more) begin
              i     <= i_next;
              t     <= t_next;
              state <= E_SM;
            end else begin
              status <= '{done: 1'b1, hit: 1'b0};
              state  <= E_IDLE;
            end
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

### src/line_of_sight_path_smoother.sv
// ----------------------------------------------------------------------------
// line_of_sight_path_smoother
// Waypoints of a path come in one beat at a time (id, signed q3.12 x and y,
// last flag) and the kept waypoints of the shortened path go out. The first
// waypoint is always kept, the second is held, and from the third on the
// segment from the anchor (last kept point) to the new waypoint is sampled at
// step_length spacing, at most MAX_SAMPLES samples. Each sample is checked
// against every gate: inside the clearance circle of a pole (circle_radius
// less 0.01) or inside the ellipse given by ellipse_sum. On a hit the held
// waypoint is sent and becomes the anchor; the waypoint with last set is
// always sent and ends the path. The first two waypoints of a path are
// handled on acceptance. Later waypoints run through one sequencer that
// shares a multiplier, a square-root unit and a divider, both SQW bits
// wide, where SQW = 2*max(COORD_WIDTH,16)+4: first the length, then per
// sample the position (the first sample sits on the anchor) and the
// gates (a hit ends the test early). in_ready stays low while a test
// runs. Results pass through a four-entry output queue; a new waypoint is
// taken while up to two results are still waiting.
// ----------------------------------------------------------------------------
module line_of_sight_path_smoother #(
  parameter int NUM_GATES   = lsps_pkg::NUM_GATES_DEF,
  parameter int MAX_SAMPLES = lsps_pkg::MAX_SAMPLES_DEF,
  parameter int COORD_WIDTH = lsps_pkg::COORD_WIDTH_DEF,
  parameter int ID_WIDTH    = lsps_pkg::ID_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]   cfg_data,
  // waypoints in
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ID_WIDTH-1:0]               node_id,
  input  logic signed [COORD_WIDTH-1:0]     pos_x,
  input  logic signed [COORD_WIDTH-1:0]     pos_y,
  input  logic                              last,
  // kept waypoints out
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ID_WIDTH-1:0]               out_id,
  output logic signed [COORD_WIDTH-1:0]     out_x,
  output logic signed [COORD_WIDTH-1:0]     out_y,
  output logic                              out_last
);

  import lsps_pkg::*;

  // only the gates that have registers take part
  localparam int GATES_USED = (NUM_GATES < GATE_REGS) ? NUM_GATES : GATE_REGS;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // path position
  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_ONE  = 2'd1;
  localparam logic [1:0] PS_MANY = 2'd2;

  // control states
  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_BUSY = 2'd1;
  localparam logic [1:0] T_LAST = 2'd2;

  typedef struct packed {
    logic [ID_WIDTH-1:0]    id;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic                   lst;
  } rec_t;

  // configuration registers
  logic [GATE_W-1:0] gate [GATE_REGS];
  logic [GATE_W-1:0] gate_use [GATES_USED];
  logic [CFG_W-1:0]  circle_radius;
  logic [CFG_W-1:0]  ellipse_sum;
  logic [CFG_W-1:0]  step_length;

  // path state
  logic signed [COORD_WIDTH-1:0] anchor_x, anchor_y, held_x, held_y;
  logic [ID_WIDTH-1:0]           anchor_id, held_id;
  logic [1:0]                    points_seen;

  // waypoint under test
  logic signed [COORD_WIDTH-1:0] cur_x, cur_y;
  logic [ID_WIDTH-1:0]           cur_id;
  logic                          cur_last;

  logic [1:0]    state;
  logic          accept;
  logic          eng_start;
  lsps_status_t  eng_status;

  // output queue
  rec_t              fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push, pop;
  rec_t              push_rec;

  // configuration is always taken; writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < GATE_REGS; j++) begin
        gate[j] <= '0;
      end
      circle_radius <= RADIUS_RST;
      ellipse_sum   <= ELLIPSE_RST;
      step_length   <= STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GATE_0:  gate[0]       <= cfg_data;
        REG_GATE_1:  gate[1]       <= cfg_data;
        REG_GATE_2:  gate[2]       <= cfg_data;
        REG_GATE_3:  gate[3]       <= cfg_data;
        REG_RADIUS:  circle_radius <= cfg_data[CFG_W-1:0];
        REG_ELLIPSE: ellipse_sum   <= cfg_data[CFG_W-1:0];
        REG_STEP:    step_length   <= cfg_data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < GATES_USED; j++) begin
      gate_use[j] = gate[j];
    end
  end

  // a waypoint may push two results, so keep two slots free
  assign in_ready  = (state == T_IDLE) && (count <= CNT_W'(FIFO_DEPTH - 2));
  assign accept    = in_valid && in_ready;
  assign eng_start = accept && (points_seen == PS_MANY);

  lsps_engine #(
    .CW (COORD_WIDTH),
    .NG (GATES_USED),
    .MS (MAX_SAMPLES)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (eng_start),
    .ax      (anchor_x),
    .ay      (anchor_y),
    .bx      (pos_x),
    .by      (pos_y),
    .gates   (gate_use),
    .radius  (circle_radius),
    .ellipse (ellipse_sum),
    .step    (step_length),
    .status  (eng_status)
  );

  // results: at most one push per cycle, held point goes before the last one
  always_comb begin
    push     = 1'b0;
    push_rec = '0;
    if (accept && (points_seen == PS_NONE)) begin
      push     = 1'b1;
      push_rec = '{id: node_id, x: pos_x, y: pos_y, lst: last};
    end else if (accept && (points_seen == PS_ONE) && last) begin
      push     = 1'b1;
      push_rec = '{id: node_id, x: pos_x, y: pos_y, lst: 1'b1};
    end else if ((state == T_BUSY) && eng_status.done) begin
      if (eng_status.hit) begin
        push     = 1'b1;
        push_rec = '{id: held_id, x: held_x, y: held_y, lst: 1'b0};
      end else if (cur_last) begin
        push     = 1'b1;
        push_rec = '{id: cur_id, x: cur_x, y: cur_y, lst: 1'b1};
      end
    end else if (state == T_LAST) begin
      push     = 1'b1;
      push_rec = '{id: cur_id, x: cur_x, y: cur_y, lst: 1'b1};
    end
  end

  // path bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      points_seen <= PS_NONE;
      anchor_x    <= '0;
      anchor_y    <= '0;
      anchor_id   <= '0;
      held_x      <= '0;
      held_y      <= '0;
      held_id     <= '0;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept) begin
            cur_id   <= node_id;
            cur_x    <= pos_x;
            cur_y    <= pos_y;
            cur_last <= last;
            case (points_seen)
              PS_NONE: begin
                anchor_x    <= pos_x;
                anchor_y    <= pos_y;
                anchor_id   <= node_id;
                held_x      <= pos_x;
                held_y      <= pos_y;
                held_id     <= node_id;
                points_seen <= last ? PS_NONE : PS_ONE;
              end
              PS_ONE: begin
                held_x      <= pos_x;
                held_y      <= pos_y;
                held_id     <= node_id;
                points_seen <= last ? PS_NONE : PS_MANY;
              end
              default: begin
                state <= T_BUSY;
              end
            endcase
          end
        end
        T_BUSY: begin
          if (eng_status.done) begin
            if (eng_status.hit) begin
              anchor_x  <= held_x;
              anchor_y  <= held_y;
              anchor_id <= held_id;
            end
            held_x      <= cur_x;
            held_y      <= cur_y;
            held_id     <= cur_id;
            points_seen <= cur_last ? PS_NONE : PS_MANY;
            state       <= (eng_status.hit && cur_last) ? T_LAST : T_IDLE;
          end
        end
        T_LAST: state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  // output queue
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_id    = fifo[rd_ptr].id;
  assign out_x     = fifo[rd_ptr].x;
  assign out_y     = fifo[rd_ptr].y;
  assign out_last  = fifo[rd_ptr].lst;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // engine only reports while a test is running
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    eng_status.done |-> (state == T_BUSY))
    else $error("engine finished outside a test");

  // queue never overruns
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  // trailing last beat state goes back to idle in the next cycle
  a_last_once: assert property (@(posedge clk) disable iff (rst)
    (state == T_LAST) |=> (state == T_IDLE))
    else $error("last beat state held");

  // a started test blocks new waypoints
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    eng_start |=> !in_ready)
    else $error("input taken during a test");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line-of-sight path smoother. Paths of random
// length and content are sent through a valid/ready driver while a shadow
// smoother predicts which waypoints are kept. A monitor compares each kept
// waypoint field by field. Gate, clearance, ellipse and step registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import lsps_pkg::*;

  localparam int IDW        = ID_WIDTH_DEF;
  localparam int CW         = COORD_WIDTH_DEF;
  localparam int SAMPLE_CAP = MAX_SAMPLES_DEF;
  // drain long enough for the worst single test
  localparam int DRAIN      = 34000;
  localparam int LIMIT      = 12000000;

  typedef struct packed {
    logic [IDW-1:0]       id;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 lst;
  } waypoint_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IDW-1:0]        node_id = '0;
  logic signed [CW-1:0]  pos_x = '0;
  logic signed [CW-1:0]  pos_y = '0;
  logic                  last = 1'b0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [IDW-1:0]        out_id;
  logic signed [CW-1:0]  out_x;
  logic signed [CW-1:0]  out_y;
  logic                  out_last;

  line_of_sight_path_smoother dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .node_id(node_id), .pos_x(pos_x),
    .pos_y(pos_y), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .out_id(out_id), .out_x(out_x),
    .out_y(out_y), .out_last(out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the registers
  logic [GATE_W-1:0] gate_q [GATE_REGS];
  logic [CFG_W-1:0]  radius_q;
  logic [CFG_W-1:0]  ellipse_q;
  logic [CFG_W-1:0]  step_q;

  // shadow path state
  waypoint_t anchor_pt;
  waypoint_t held_pt;
  int        path_count;

  waypoint_t pending_wps[$];
  waypoint_t kept_points[$];

  int  errors = 0;
  int  cyc = 0;
  int  beats_in = 0;
  bit  in_took = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned pole_dist(longint ax, longint ay, longint bx, longint by);
    longint unsigned ex;
    longint unsigned ey;
    ex = mag(ax - bx);
    ey = mag(ay - by);
    return isqrt(ex * ex + ey * ey);
  endfunction

  // rounded (half away from zero) fraction of a delta
  function automatic longint part_of(longint d, longint unsigned t, longint unsigned len);
    longint unsigned q;
    q = (mag(d) * t * 2 + len) / (2 * len);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit segment_blocked(longint ax, longint ay, longint bx, longint by);
    longint          dx;
    longint          dy;
    longint unsigned len;
    longint unsigned stp;
    longint unsigned ns;
    longint          r;
    longint          sx;
    longint          sy;
    longint unsigned dl;
    longint unsigned dr;
    logic [GATE_W-1:0] g;
    dx  = bx - ax;
    dy  = by - ay;
    len = isqrt(mag(dx) * mag(dx) + mag(dy) * mag(dy));
    stp = (step_q != 0) ? longint'(step_q) : 1;
    ns  = len / stp + 1;
    r   = longint'(radius_q) - longint'(CLEAR_MARGIN);
    if (ns > SAMPLE_CAP) ns = SAMPLE_CAP;
    for (longint unsigned i = 0; i < ns; i++) begin
      sx = ax;
      sy = ay;
      if (len != 0) begin
        sx = sx + part_of(dx, i * stp, len);
        sy = sy + part_of(dy, i * stp, len);
      end
      for (int k = 0; k < NUM_GATES_DEF && k < GATE_REGS; k++) begin
        g  = gate_q[k];
        dl = pole_dist(sx, sy, longint'($signed(g[15:0])), longint'($signed(g[31:16])));
        dr = pole_dist(sx, sy, longint'($signed(g[47:32])), longint'($signed(g[63:48])));
        if (r > 0 && (dl < r || dr < r)) return 1'b1;
        if (dl + dr < ellipse_q) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void smooth_waypoint(waypoint_t w);
    waypoint_t k;
    if (path_count == 0) begin
      kept_points = {kept_points, w};
      anchor_pt  = w;
      path_count = 1;
    end else if (path_count == 1) begin
      if (w.lst) kept_points = {kept_points, w};
      path_count = 2;
    end else begin
      if (segment_blocked(anchor_pt.x, anchor_pt.y, w.x, w.y)) begin
        k     = held_pt;
        k.lst = 1'b0;
        kept_points = {kept_points, k};
        anchor_pt = held_pt;
      end
      if (w.lst) kept_points = {kept_points, w};
    end
    held_pt = w;
    if (w.lst) path_count = 0;
  endfunction

  function automatic void reset_shadow();
    for (int k = 0; k < GATE_REGS; k++) gate_q[k] = '0;
    radius_q   = RADIUS_RST;
    ellipse_q  = ELLIPSE_RST;
    step_q     = STEP_RST;
    anchor_pt  = '0;
    held_pt    = '0;
    path_count = 0;
  endfunction

  // quiet window in the middle of the random part: no idling on either side
  function automatic bit quiet_window();
    return beats_in >= 500 && beats_in < 650;
  endfunction

  // accept side: count cycles, predict on input beats, check output beats
  always @(posedge clk) begin
    waypoint_t got;
    waypoint_t exp_w;
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst && in_valid && in_ready) begin
      smooth_waypoint('{id: node_id, x: pos_x, y: pos_y, lst: last});
      beats_in = beats_in + 1;
      in_took  = 1'b1;
    end
    if (!rst && out_valid && out_ready) begin
      got = '{id: out_id, x: out_x, y: out_y, lst: out_last};
      if (kept_points.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10)
          $display("unexpected beat: id %0d x %0d y %0d last %0b",
                   got.id, got.x, got.y, got.lst);
      end else begin
        exp_w = kept_points.pop_front();
        if (got !== exp_w) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("mismatch: expected id %0d x %0d y %0d last %0b, got id %0d x %0d y %0d last %0b",
                     exp_w.id, exp_w.x, exp_w.y, exp_w.lst, got.id, got.x, got.y, got.lst);
        end
      end
    end
  end

  // waypoint driver: next beat after acceptance or while idle
  always @(negedge clk) begin
    waypoint_t w;
    if (rst) begin
      in_valid <= 1'b0;
      in_took = 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (pending_wps.size() > 0 && (quiet_window() || $urandom_range(99) >= 25)) begin
        w = pending_wps.pop_front();
        in_valid <= 1'b1;
        node_id  <= w.id;
        pos_x    <= w.x;
        pos_y    <= w.y;
        last     <= w.lst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && beats_in >= 200) begin
      hold_done = 1'b1;
      hold_left = 4000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_window() || ($urandom_range(99) >= 25);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < GATE_REGS) gate_q[idx] = val;
    else if (idx == REG_RADIUS) radius_q = val[CFG_W-1:0];
    else if (idx == REG_ELLIPSE) ellipse_q = val[CFG_W-1:0];
    else if (idx == REG_STEP) step_q = val[CFG_W-1:0];
  endtask

  task automatic load_settings(input logic [GATE_W-1:0] g0, input logic [GATE_W-1:0] g1,
                               input logic [GATE_W-1:0] g2, input logic [GATE_W-1:0] g3,
                               input int rad, input int ell, input int stp);
    write_reg(REG_GATE_0, g0);
    write_reg(REG_GATE_1, g1);
    write_reg(REG_GATE_2, g2);
    write_reg(REG_GATE_3, g3);
    write_reg(REG_RADIUS, CFG_DATA_W'(rad));
    write_reg(REG_ELLIPSE, CFG_DATA_W'(ell));
    write_reg(REG_STEP, CFG_DATA_W'(stp));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_wp(input int id, input int x, input int y, input bit lst);
    waypoint_t w;
    w = '{id: id[IDW-1:0], x: x[CW-1:0], y: y[CW-1:0], lst: lst};
    pending_wps = {pending_wps, w};
  endtask

  // one path of random length; mostly a random walk, sometimes scattered
  task automatic push_path();
    int  n;
    int  x;
    int  y;
    bit  scatter;
    n = $urandom_range(9, 1);
    scatter = ($urandom_range(99) < 20);
    x = $signed($urandom_range(65535)) - 32768;
    y = $signed($urandom_range(65535)) - 32768;
    for (int k = 0; k < n; k++) begin
      if (scatter) begin
        x = $urandom_range(65535) - 32768;
        y = $urandom_range(65535) - 32768;
      end else begin
        x = x + $urandom_range(8192) - 4096;
        y = y + $urandom_range(8192) - 4096;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
      end
      push_wp($urandom_range(4095), x, y, k == n - 1);
    end
  endtask

  // all beats accepted and answered, then let any silent test finish
  task automatic settle();
    while (pending_wps.size() > 0 || in_valid || kept_points.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_phase(input int n_items);
    int target;
    target = beats_in + n_items;
    while (beats_in + pending_wps.size() < target) push_path();
    settle();
  endtask

  function automatic logic [GATE_W-1:0] rand_gate();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: every gate pole at the origin
    // single-point path with extreme fields
    push_wp(4095, -32768, 32767, 1'b1);
    // two-point path passes unchanged
    push_wp(0, 0, 0, 1'b0);
    push_wp(1, 32767, -32768, 1'b1);
    // corner to corner through the poles: capped samples stop short of them, so the last point goes out alone
    push_wp(2, -32768, -32768, 1'b0);
    push_wp(3, 100, 100, 1'b0);
    push_wp(4, 32767, 32767, 1'b1);
    // zero-length segment back onto the anchor
    push_wp(5, 5000, 5000, 1'b0);
    push_wp(6, 6000, 6000, 1'b0);
    push_wp(7, 5000, 5000, 1'b1);
    settle();

    // step of zero, clearance at the margin so only the ellipse can fire
    load_settings(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_8000_7FFF_8000, 64'h1234_5678_9ABC_DEF0,
                  41, 32767, 0);
    push_wp(8, -20000, 3000, 1'b0);
    push_wp(9, -10000, 3100, 1'b0);
    push_wp(10, 0, 3200, 1'b0);
    push_wp(11, 10000, 3300, 1'b1);
    settle();

    // smallest step, nothing can collide, short segments keep it cheap
    load_settings(rand_gate(), rand_gate(), rand_gate(), rand_gate(), 0, 0, 1);
    push_wp(12, 100, 100, 1'b0);
    push_wp(13, 104, 103, 1'b0);
    push_wp(14, 108, 107, 1'b0);
    push_wp(15, 111, 109, 1'b1);
    settle();

    load_settings(rand_gate(), rand_gate(), rand_gate(), rand_gate(), 1024, 2990, 32767);
    random_phase(250);
    load_settings(rand_gate(), rand_gate(), rand_gate(), rand_gate(), 32767, 0, 16384);
    random_phase(200);
    load_settings(64'hFFFF_FFFF_FFFF_FFFF, rand_gate(), 64'h0, rand_gate(),
                  $urandom_range(32767), $urandom_range(8000), $urandom_range(32767, 12000));
    random_phase(300);
    load_settings(rand_gate(), rand_gate(), rand_gate(), rand_gate(),
                  $urandom_range(32767), $urandom_range(32767), $urandom_range(32767, 12000));
    random_phase(250);

    if (errors == 0 && kept_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
